// ===== src/fmdh_pkg.sv =====
package fmdh_pkg;

    localparam int MODE_W     = 2;
    localparam int BLOCK_W    = 14;
    localparam int NODE_W     = 4;
    localparam int NODE_CNT_W = 5;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 20;

    localparam int RENEW_CNT_W = 4;
    localparam logic [RENEW_CNT_W-1:0] MAX_RENEWS = 4'd15;

    localparam logic [MODE_W-1:0] MODE_READ_MISS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_MISS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WRITEBACK  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_RENEW    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OK       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_HOME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE   = 1'd1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BLOCK_W-1:0] block_number;
        logic [NODE_W-1:0]  src_node;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [NODE_W-1:0]  dest_node;
        logic [BLOCK_W-1:0] block_out;
        logic               last;
    } rsp_t;

    // floor(2^RECIP_SHIFT / n)
    function automatic logic [RECIP_W-1:0] recip(input logic [NODE_CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            5'd2:    r = 20'd262144;
            5'd3:    r = 20'd174762;
            5'd4:    r = 20'd131072;
            5'd5:    r = 20'd104857;
            5'd6:    r = 20'd87381;
            5'd7:    r = 20'd74898;
            5'd8:    r = 20'd65536;
            5'd9:    r = 20'd58254;
            5'd10:   r = 20'd52428;
            5'd11:   r = 20'd47662;
            5'd12:   r = 20'd43690;
            5'd13:   r = 20'd40329;
            5'd14:   r = 20'd37449;
            5'd15:   r = 20'd34952;
            5'd16:   r = 20'd32768;
            5'd17:   r = 20'd30840;
            5'd18:   r = 20'd29127;
            5'd19:   r = 20'd27594;
            5'd20:   r = 20'd26214;
            5'd21:   r = 20'd24966;
            5'd22:   r = 20'd23831;
            5'd23:   r = 20'd22795;
            5'd24:   r = 20'd21845;
            5'd25:   r = 20'd20971;
            5'd26:   r = 20'd20164;
            5'd27:   r = 20'd19418;
            5'd28:   r = 20'd18724;
            5'd29:   r = 20'd18078;
            5'd30:   r = 20'd17476;
            5'd31:   r = 20'd16912;
            default: r = 20'd524288;
        endcase
        return r;
    endfunction

endpackage

// ===== src/fmdh_ram.sv =====
module fmdh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fmdh_div.sv =====
module fmdh_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fmdh_pkg::BLOCK_W-1:0]    dividend,
    input  logic [fmdh_pkg::NODE_CNT_W-1:0] divisor,
    output logic                           done,
    output logic [fmdh_pkg::BLOCK_W-1:0]    quot,
    output logic [fmdh_pkg::NODE_CNT_W-1:0] rem
);
    import fmdh_pkg::*;

    localparam int PROD_W = BLOCK_W + RECIP_W;
    localparam int QN_W   = BLOCK_W + NODE_CNT_W;
    localparam int REM2_W = NODE_CNT_W + 1;

    logic                  s1_valid_reg;
    logic                  s2_valid_reg;
    logic                  done_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [BLOCK_W-1:0]    dvd1_reg;
    logic [NODE_CNT_W-1:0] dvs1_reg;
    logic [BLOCK_W-1:0]    q0_reg;
    logic [NODE_CNT_W-1:0] dvs2_reg;
    logic [REM2_W-1:0]     rem2_reg;
    logic [BLOCK_W-1:0]    quot_reg;
    logic [NODE_CNT_W-1:0] rem_reg;

    logic [BLOCK_W-1:0]    q0;
    logic [QN_W-1:0]       qn;
    logic [BLOCK_W-1:0]    diff;
    logic                  fix;

    assign q0   = prod_reg[RECIP_SHIFT +: BLOCK_W];
    assign qn   = QN_W'(q0) * QN_W'(dvs1_reg);
    assign diff = dvd1_reg - BLOCK_W'(qn);
    assign fix  = rem2_reg >= {1'b0, dvs2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(recip(divisor));
            dvd1_reg <= dividend;
            dvs1_reg <= divisor;
        end
        if (s1_valid_reg)
        begin
            q0_reg   <= q0;
            dvs2_reg <= dvs1_reg;
            rem2_reg <= REM2_W'(diff);
        end
        if (s2_valid_reg)
        begin
            quot_reg <= fix ? q0_reg + BLOCK_W'(1) : q0_reg;
            rem_reg  <= fix ? NODE_CNT_W'(rem2_reg - {1'b0, dvs2_reg})
                            : NODE_CNT_W'(rem2_reg);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/full_map_directory_home_unit.sv =====
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | fmdh_pkg::req_t
// rsp     | out       | rsp_valid/rsp_ready  | fmdh_pkg::rsp_t
// cfg     | in        | cfg_write            | cfg_index, cfg_data
//
// A request is accepted, then the reciprocal divider splits the block number into
// home and entry index, the directory is read, and the results follow one transfer
// per cycle while rsp is not stalled; a bad-home request skips the read.
// After reset the directory is cleared one entry per cycle, with req_ready low;
// cfg writes are taken throughout.
// A stalled rsp holds the engine on its next result; the next request is taken
// while the last completion still waits in the output register.
module full_map_directory_home_unit #(
    parameter int MAX_NODES    = 16,
    parameter int HOME_ENTRIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  fmdh_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output fmdh_pkg::rsp_t                 rsp,
    input  logic                           cfg_write,
    input  logic [fmdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmdh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fmdh_pkg::*;

    localparam int IDX_W = (HOME_ENTRIES > 1) ? $clog2(HOME_ENTRIES) : 1;
    localparam int NI_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [NODE_CNT_W-1:0]  node_count_reg;
    logic [NODE_W-1:0]      own_node_reg;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [BLOCK_W-1:0]     blk_reg, blk_next;
    logic [NODE_W-1:0]      src_reg, src_next;
    logic [NODE_CNT_W-1:0]  nodes_reg, nodes_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [MAX_NODES-1:0]   pending_reg, pending_next;
    logic [RENEW_CNT_W-1:0] renew_cnt_reg, renew_cnt_next;
    logic [KIND_W-1:0]      final_kind_reg, final_kind_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [NODE_CNT_W-1:0]  nodes_eff;
    logic                   div_start;
    logic                   div_done;
    logic [BLOCK_W-1:0]     div_quot;
    logic [NODE_CNT_W-1:0]  div_rem;
    logic                   bad_home;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [MAX_NODES-1:0]   ram_wdata;
    logic                   ram_re;
    logic [MAX_NODES-1:0]   ram_rdata;

    logic [MAX_NODES-1:0]   below_mask;
    logic [MAX_NODES-1:0]   src_bit;
    logic [NI_W-1:0]        first_idx;
    logic                   out_free;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            nodes_eff = NODE_CNT_W'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            nodes_eff = NODE_CNT_W'(MAX_NODES);
        end
        else
        begin
            nodes_eff = node_count_reg;
        end
    end

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            below_mask[i] = 32'(i) < 32'(nodes_reg);
            src_bit[i]    = 32'(src_reg) == 32'(i);
        end
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                first_idx = NI_W'(i);
            end
        end
    end

    assign bad_home = (div_rem != {1'b0, own_node_reg}) || (32'(div_quot) >= HOME_ENTRIES);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = state_reg == ST_IDLE;

    fmdh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.block_number),
        .divisor  (nodes_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    fmdh_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (HOME_ENTRIES)
    ) u_dir (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (IDX_W'(div_quot)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mode_next       = mode_reg;
        blk_next        = blk_reg;
        src_next        = src_reg;
        nodes_next      = nodes_reg;
        idx_next        = idx_reg;
        pending_next    = pending_reg;
        renew_cnt_next  = renew_cnt_reg;
        final_kind_next = final_kind_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;

        case (state_reg)
            ST_CLR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(HOME_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    blk_next   = req.block_number;
                    src_next   = req.src_node;
                    nodes_next = nodes_eff;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    renew_cnt_next = '0;
                    pending_next   = '0;
                    idx_next       = IDX_W'(div_quot);
                    if (bad_home)
                    begin
                        final_kind_next = KIND_BAD_HOME;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        final_kind_next = KIND_OK;
                        ram_re          = 1'b1;
                        state_next      = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                case (mode_reg)
                    MODE_READ_MISS:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | src_bit;
                    end
                    MODE_WRITE_MISS:
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata | src_bit;
                        pending_next = ram_rdata & ~src_bit & below_mask;
                    end
                    MODE_WRITE:
                    begin
                        pending_next = ram_rdata & ~src_bit & below_mask;
                    end
                    default:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~src_bit;
                    end
                endcase
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.block_out = blk_reg;
                    if (pending_reg != '0 && renew_cnt_reg != MAX_RENEWS)
                    begin
                        rsp_next.kind      = KIND_RENEW;
                        rsp_next.dest_node = NODE_W'(first_idx);
                        rsp_next.last      = 1'b0;
                        pending_next       = pending_reg & (pending_reg - MAX_NODES'(1));
                        renew_cnt_next     = renew_cnt_reg + RENEW_CNT_W'(1);
                    end
                    else
                    begin
                        rsp_next.kind      = final_kind_reg;
                        rsp_next.dest_node = src_reg;
                        rsp_next.last      = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_cnt_reg    <= '0;
            node_count_reg <= NODE_CNT_W'(1);
            own_node_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            pending_reg    <= '0;
            renew_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            pending_reg   <= pending_next;
            renew_cnt_reg <= renew_cnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= NODE_CNT_W'(cfg_data);
                    CFG_OWN_NODE:   own_node_reg   <= NODE_W'(cfg_data);
                    default:        own_node_reg   <= own_node_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        blk_reg        <= blk_next;
        src_reg        <= src_next;
        nodes_reg      <= nodes_next;
        idx_reg        <= idx_next;
        final_kind_reg <= final_kind_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_RD || state_reg == ST_CLR))
        else $error("directory write outside clear or update slot");

    a_renew_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.last || rsp_reg.kind == KIND_RENEW))
        else $error("non-final result is not a renew");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished with no request waiting");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> (pending_reg & ~below_mask) == '0)
        else $error("renew pending beyond node count");
`endif

endmodule

// ===== tb/tb_full_map_directory_home_unit.sv =====
module tb_full_map_directory_home_unit;
    import fmdh_pkg::*;

    localparam int NODES_MAX   = 16;
    localparam int DIR_DEPTH   = 1024;
    localparam int RESULTS_MAX = 16;
    localparam int HOLD_CYCLES = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_NODE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [NODES_MAX-1:0]  sharers [DIR_DEPTH];
    logic [NODE_CNT_W-1:0] node_count_reg;
    logic [NODE_W-1:0]     own_node_reg;
    rsp_t                  outgoing_msgs [$];

    bit failed          = 1'b0;
    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;
    bit hold_off_start  = 1'b0;
    int burst_left      = 0;
    int hold_left       = 0;
    int stall_left      = 0;

    full_map_directory_home_unit #(
        .MAX_NODES    (NODES_MAX),
        .HOME_ENTRIES (DIR_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned active_nodes();
        if (node_count_reg == 0)
            return 1;
        if (node_count_reg > NODES_MAX)
            return NODES_MAX;
        return 32'(node_count_reg);
    endfunction

    function automatic logic [BLOCK_W-1:0] home_block(input int unsigned idx);
        return BLOCK_W'(idx * active_nodes() + own_node_reg);
    endfunction

    function automatic req_t make_req(input logic [MODE_W-1:0] mode,
                                      input int unsigned blk, input int unsigned src);
        req_t r;
        r.mode         = mode;
        r.block_number = BLOCK_W'(blk);
        r.src_node     = NODE_W'(src);
        return r;
    endfunction

    function automatic void apply_request(input req_t r);
        int unsigned          nodes;
        int unsigned          home;
        int unsigned          idx;
        int unsigned          renews;
        logic [NODES_MAX-1:0] old_map;
        logic [NODES_MAX-1:0] src_bit;
        rsp_t                 m;

        nodes = active_nodes();
        home  = r.block_number % nodes;
        idx   = r.block_number / nodes;
        m.block_out = r.block_number;
        if (home != own_node_reg || idx >= DIR_DEPTH)
        begin
            m.kind      = KIND_BAD_HOME;
            m.dest_node = r.src_node;
            m.last      = 1'b1;
            outgoing_msgs.push_back(m);
            return;
        end
        old_map = sharers[idx];
        src_bit = '0;
        if (r.src_node < NODES_MAX)
            src_bit[r.src_node] = 1'b1;
        renews = 0;
        if (r.mode == MODE_WRITE_MISS || r.mode == MODE_WRITE)
        begin
            for (int i = 0; i < nodes && renews < RESULTS_MAX - 1; i++)
            begin
                if (old_map[i] && i != r.src_node)
                begin
                    m.kind      = KIND_RENEW;
                    m.dest_node = NODE_W'(i);
                    m.last      = 1'b0;
                    outgoing_msgs.push_back(m);
                    renews++;
                end
            end
        end
        case (r.mode)
            MODE_READ_MISS, MODE_WRITE_MISS: sharers[idx] = old_map | src_bit;
            MODE_WRITEBACK:                  sharers[idx] = old_map & ~src_bit;
            default:                         ;
        endcase
        m.kind      = KIND_OK;
        m.dest_node = r.src_node;
        m.last      = 1'b1;
        outgoing_msgs.push_back(m);
    endfunction

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (outgoing_msgs.size() == 0)
            begin
                $error("unexpected transfer: kind %0d dest_node %0d block_out %0d last %0d",
                       rsp.kind, rsp.dest_node, rsp.block_out, rsp.last);
                failed = 1'b1;
            end
            else
            begin
                want = outgoing_msgs.pop_front();
                if (rsp.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
                    failed = 1'b1;
                end
                if (rsp.dest_node !== want.dest_node)
                begin
                    $error("dest_node: expected %0d, actual %0d", want.dest_node, rsp.dest_node);
                    failed = 1'b1;
                end
                if (rsp.block_out !== want.block_out)
                begin
                    $error("block_out: expected %0d, actual %0d", want.block_out, rsp.block_out);
                    failed = 1'b1;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp.last);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_start)
        begin
            hold_left      = HOLD_CYCLES;
            hold_off_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    task automatic send_request(input req_t r);
        if (sender_gaps && burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        apply_request(r);
    endtask

    task automatic configure(input int unsigned nodes, input int unsigned own);
        req_valid <= 1'b0;
        @(posedge clk);
        while (outgoing_msgs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= CFG_DATA_W'(nodes);
        @(posedge clk);
        cfg_index <= CFG_OWN_NODE;
        cfg_data  <= CFG_DATA_W'(own);
        @(posedge clk);
        cfg_write <= 1'b0;
        node_count_reg = NODE_CNT_W'(nodes);
        own_node_reg   = NODE_W'(own);
    endtask

    task automatic test_modes();
        logic [BLOCK_W-1:0] b;
        configure(4, 1);
        b = home_block(3);
        send_request(make_req(MODE_READ_MISS, b, 2));
        send_request(make_req(MODE_READ_MISS, b, 1));
        send_request(make_req(MODE_READ_MISS, b, 9));
        send_request(make_req(MODE_WRITE_MISS, b, 0));
        send_request(make_req(MODE_WRITE, b, 2));
        send_request(make_req(MODE_WRITEBACK, b, 2));
        send_request(make_req(MODE_WRITE, b, 3));
    endtask

    task automatic test_foreign_home();
        configure(4, 1);
        send_request(make_req(MODE_READ_MISS, 14, 1));
        send_request(make_req(MODE_WRITE, 0, 0));
        send_request(make_req(MODE_WRITEBACK, 16383, 15));
        send_request(make_req(MODE_READ_MISS, 16381, 3));
        send_request(make_req(MODE_WRITE_MISS, 15, 2));
    endtask

    task automatic test_node_count_limits();
        configure(0, 0);
        send_request(make_req(MODE_READ_MISS, 0, 15));
        send_request(make_req(MODE_WRITE_MISS, 1023, 0));
        send_request(make_req(MODE_READ_MISS, 1024, 4));
        send_request(make_req(MODE_WRITE, 16383, 7));
        configure(31, 15);
        send_request(make_req(MODE_READ_MISS, 16383, 15));
        send_request(make_req(MODE_WRITE, 16383, 0));
        send_request(make_req(MODE_WRITEBACK, 16383, 15));
    endtask

    task automatic test_backpressure();
        logic [BLOCK_W-1:0] b;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        configure(16, 0);
        b = home_block(5);
        for (int s = 0; s < NODES_MAX; s++)
            send_request(make_req(MODE_READ_MISS, b, s));
        hold_off_start = 1'b1;
        for (int k = 0; k < 12; k++)
            send_request(make_req(k[0] ? MODE_WRITE_MISS : MODE_WRITE, b,
                                  $urandom_range(0, NODES_MAX - 1)));
    endtask

    task automatic test_random_traffic(input int total);
        int unsigned        nodes;
        int unsigned        own;
        int unsigned        idx;
        int unsigned        blk;
        int unsigned        src;
        logic [MODE_W-1:0]  mode;

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       nodes = 16;
                1:       nodes = 1;
                default: nodes = $urandom_range(0, 31);
            endcase
            node_count_reg = NODE_CNT_W'(nodes);
            if ($urandom_range(0, 4) == 0)
                own = $urandom_range(0, 15);
            else
                own = $urandom_range(0, active_nodes() - 1);
            configure(nodes, own);
            nodes           = active_nodes();
            sender_gaps     = (phase != 2);
            receiver_stalls = (phase != 3);
            for (int k = 0; k < total / 5; k++)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    idx = $urandom_range(0, 7);
                    if ($urandom_range(0, 4) == 0)
                        idx = DIR_DEPTH - 1 - idx;
                    blk = home_block(idx);
                end
                else
                    blk = $urandom_range(0, 16383);
                if ($urandom_range(0, 9) < 7)
                    src = $urandom_range(0, nodes - 1);
                else
                    src = $urandom_range(0, 15);
                mode = MODE_W'($urandom_range(0, 3));
                send_request(make_req(mode, blk, src));
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        wait_cycles = 0;
        foreach (sharers[i])
            sharers[i] = '0;
        node_count_reg = NODE_CNT_W'(1);
        own_node_reg   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modes();
        test_foreign_home();
        test_node_count_limits();
        test_backpressure();
        test_random_traffic(150);

        req_valid <= 1'b0;
        while (outgoing_msgs.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30) @(posedge clk);
        if (outgoing_msgs.size() != 0)
        begin
            $error("%0d results never arrived", outgoing_msgs.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
